// ===== rtl/core/gwm_pkg.sv =====
`timescale 1ns / 1ps

package gwm_pkg;

  localparam int PATTERN_MAX_DEF = 256;

  localparam logic [7:0] STAR_CHAR = 8'h2a;
  localparam logic [7:0] ANY_CHAR  = 8'h3f;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5a;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] character;
  } req_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } rsp_t;

  // one stored pattern position, byte already lower-cased
  typedef struct packed {
    logic       valid;
    logic       star;
    logic       any;
    logic [7:0] ch;
  } ent_t;

  // handed from a cell to its right-hand neighbour
  typedef struct packed {
    logic adv;
    logic raw_star;
    logic valid_n;
    logic start_star;
  } lnk_t;

  // broadcast to every cell
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       rearm;
    logic       text;
    logic [7:0] tc;
  } ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gwm_cell.sv =====
`timescale 1ns / 1ps

module gwm_cell (
  input  logic          clk,
  input  logic          rst,
  input  gwm_pkg::ctl_t ctl,
  input  gwm_pkg::ent_t ent_in,
  output gwm_pkg::ent_t ent,
  input  gwm_pkg::lnk_t lnk_in,
  output gwm_pkg::lnk_t lnk
);
  import gwm_pkg::*;

  logic active;
  logic active_next;
  ent_t ent_next;
  logic hit;
  logic raw;
  logic start_n;

  always_comb begin
    ent_next = ent;
    if (ctl.clear) begin
      ent_next.valid = 1'b0;
    end else if (ctl.shift) begin
      ent_next = ent_in;
    end
  end

  always_comb begin
    hit     = active & ent.valid & ~ent.star & (ent.any | (ent.ch == ctl.tc));
    raw     = lnk_in.adv | (active & ent.valid & ent.star);
    start_n = ent_next.valid & ~lnk_in.valid_n;

    lnk.adv        = hit;
    lnk.raw_star   = raw & ent.valid & ent.star;
    lnk.valid_n    = ent_next.valid;
    lnk.start_star = start_n & ent_next.star;

    active_next = active;
    if (ctl.rearm) begin
      active_next = start_n | lnk_in.start_star;
    end else if (ctl.text) begin
      active_next = raw | lnk_in.raw_star;
    end
  end

  always_ff @(posedge clk) begin
    ent.star <= ent_next.star;
    ent.any  <= ent_next.any;
    ent.ch   <= ent_next.ch;
    if (rst) begin
      active    <= 1'b0;
      ent.valid <= 1'b0;
    end else begin
      active    <= active_next;
      ent.valid <= ent_next.valid;
    end
  end

endmodule

// ===== rtl/core/glob_wildcard_matcher_top.sv =====
`timescale 1ns / 1ps

// Case-insensitive glob matcher. Takes one transaction per clock: clear, append pattern
// byte, text byte or end of text, except that an end of text waits while the last result
// is not yet taken. The pattern sits right-aligned in a row of PATTERN_MAX cells; an append
// shifts the row left by one cell, with runs of '*' kept as one, and every text byte
// updates all cells at once from their neighbours. End of text returns matched and
// pattern_overflow in the next cycle from an output register; other transactions are
// taken even while that result waits. The row needs no clearing pass after reset.

module glob_wildcard_matcher_top #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gwm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gwm_pkg::rsp_t rsp
);
  import gwm_pkg::*;

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  ent_t ents [PATTERN_MAX];
  lnk_t lnks [PATTERN_MAX];

  ctl_t             ctl;
  ent_t             new_ent;
  ent_t             tail;
  lnk_t             last;
  logic             take;
  logic             is_clear;
  logic             is_append;
  logic             is_text;
  logic             is_end;
  logic             room;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             overflow;
  logic             overflow_next;
  logic             accept;
  logic             accept_next;

  assign take      = req_valid & req_ready;
  assign req_ready = (req.kind != KIND_END) | ~rsp_valid | rsp_ready;

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_text   = 1'b0;
    is_end    = 1'b0;
    case (req.kind)
      KIND_CLEAR:  is_clear  = take;
      KIND_APPEND: is_append = take;
      KIND_TEXT:   is_text   = take;
      KIND_END:    is_end    = take;
      default:     is_end    = 1'b0;
    endcase
  end

  assign tail = ents[PATTERN_MAX-1];
  assign last = lnks[PATTERN_MAX-1];
  assign room = cnt < CNT_W'(PATTERN_MAX);

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.ch    = fold_case(req.character);
    new_ent.star  = (new_ent.ch == STAR_CHAR);
    new_ent.any   = (new_ent.ch == ANY_CHAR);

    ctl.clear = is_clear;
    ctl.shift = is_append & room & ~(new_ent.star & tail.valid & tail.star);
    ctl.rearm = is_clear | is_append | is_end;
    ctl.text  = is_text;
    ctl.tc    = new_ent.ch;
  end

  always_comb begin
    cnt_next      = cnt;
    overflow_next = overflow;
    if (is_clear) begin
      cnt_next      = '0;
      overflow_next = 1'b0;
    end else if (is_append) begin
      if (room) begin
        cnt_next = cnt + CNT_W'(1);
      end else begin
        overflow_next = 1'b1;
      end
    end
  end

  always_comb begin
    accept_next = accept;
    if (ctl.rearm) begin
      accept_next = ~last.valid_n | last.start_star;
    end else if (ctl.text) begin
      accept_next = last.adv | last.raw_star;
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    ent_t ent_in;
    lnk_t lnk_in;
    if (i == PATTERN_MAX - 1) begin : g_right
      assign ent_in = new_ent;
    end else begin : g_mid
      assign ent_in = ents[i+1];
    end
    if (i == 0) begin : g_left
      assign lnk_in = '0;
    end else begin : g_inner
      assign lnk_in = lnks[i-1];
    end
    gwm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .ent_in (ent_in),
      .ent    (ents[i]),
      .lnk_in (lnk_in),
      .lnk    (lnks[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      overflow  <= 1'b0;
      accept    <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      cnt      <= cnt_next;
      overflow <= overflow_next;
      accept   <= accept_next;
      if (is_end) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      rsp.matched          <= accept;
      rsp.pattern_overflow <= overflow;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(PATTERN_MAX))
    else $error("pattern count beyond store");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    is_clear |=> (cnt == '0) && !overflow && !tail.valid && accept)
    else $error("clear left pattern state behind");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (cnt == CNT_W'(PATTERN_MAX)))
    else $error("overflow flagged with room left");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) == !tail.valid)
    else $error("cell row and pattern count disagree");

  a_result: assert property (@(posedge clk) disable iff (rst)
    is_end |=> rsp_valid && (rsp.pattern_overflow == $past(overflow)))
    else $error("end of text gave no result");

endmodule

// ===== bench/glob_wildcard_matcher_top_tb.sv =====
`timescale 1ns / 1ps

module glob_wildcard_matcher_top_tb;
  import gwm_pkg::*;

  localparam int PMAX = PATTERN_MAX_DEF;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  glob_wildcard_matcher_top #(
    .PATTERN_MAX(PMAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // golden copy of the matcher
  logic [7:0] pat_bytes [PMAX];
  int pat_len;
  bit [PMAX:0] live;
  bit overflow_flag;
  rsp_t expected_verdicts [$];
  rsp_t want;

  int error_count;
  int items_sent;
  int verdict_count;
  int match_count;
  int overflow_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  logic [7:0] pat_plan [$];
  logic [7:0] text_plan [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7a;
  endfunction

  function automatic void spread_stars();
    for (int p = 0; p < pat_len; p++) begin
      if (live[p] && pat_bytes[p] == STAR_CHAR) begin
        live[p + 1] = 1'b1;
      end
    end
  endfunction

  function automatic void rearm_positions();
    live = '0;
    live[0] = 1'b1;
    spread_stars();
  endfunction

  function automatic void advance_positions(input logic [7:0] c);
    bit [PMAX:0] nxt;
    logic [7:0] tc;
    nxt = '0;
    tc = lower_ascii(c);
    for (int p = 0; p < pat_len; p++) begin
      if (live[p]) begin
        if (pat_bytes[p] == STAR_CHAR) begin
          nxt[p] = 1'b1;
        end else if (pat_bytes[p] == ANY_CHAR || lower_ascii(pat_bytes[p]) == tc) begin
          nxt[p + 1] = 1'b1;
        end
      end
    end
    live = nxt;
    spread_stars();
  endfunction

  function automatic void predict_transaction(input req_t r);
    case (r.kind)
      KIND_CLEAR: begin
        pat_len = 0;
        overflow_flag = 1'b0;
        rearm_positions();
      end
      KIND_APPEND: begin
        if (pat_len < PMAX) begin
          pat_bytes[pat_len] = r.character;
          pat_len++;
        end else begin
          overflow_flag = 1'b1;
        end
        rearm_positions();
      end
      KIND_TEXT: begin
        advance_positions(r.character);
      end
      default: begin
        expected_verdicts.push_back('{matched: live[pat_len], pattern_overflow: overflow_flag});
        rearm_positions();
      end
    endcase
  endfunction

  // predict on request, check on response
  always @(posedge clk) begin
    if (rst) begin
      pat_len = 0;
      overflow_flag = 1'b0;
      rearm_positions();
    end else begin
      if (req_valid && req_ready) begin
        predict_transaction(req);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected response transaction: matched %0b, pattern_overflow %0b",
                 rsp.matched, rsp.pattern_overflow);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          verdict_count++;
          if (want.matched) match_count++;
          if (want.pattern_overflow) overflow_count++;
          if (rsp.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, rsp.matched);
            error_count++;
          end
          if (rsp.pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, got %0b",
                   want.pattern_overflow, rsp.pattern_overflow);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input kind_t k, input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{kind: k, character: c};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_verdicts();
    req_valid <= 1'b0;
    @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic send_text_and_end();
    foreach (text_plan[i]) send_item(KIND_TEXT, text_plan[i]);
    send_item(KIND_END, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(2));
    if ($urandom_range(1)) c = c - CASE_GAP;
    return c;
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(9))
      0, 1: return STAR_CHAR;
      2: return ANY_CHAR;
      3: return 8'($urandom_range(255));
      default: return pick_letter();
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    return $urandom_range(3) == 0 ? 8'($urandom_range(255)) : pick_letter();
  endfunction

  // text built to fit the planned pattern, optionally spoilt afterwards
  function automatic void build_text(input bit spoil);
    int pos;
    text_plan.delete();
    foreach (pat_plan[i]) begin
      if (pat_plan[i] == STAR_CHAR) begin
        repeat ($urandom_range(3)) text_plan.push_back(pick_text_byte());
      end else if (pat_plan[i] == ANY_CHAR) begin
        text_plan.push_back(pick_text_byte());
      end else if (is_letter(pat_plan[i]) && $urandom_range(1)) begin
        text_plan.push_back(pat_plan[i] ^ CASE_GAP);
      end else begin
        text_plan.push_back(pat_plan[i]);
      end
    end
    if (spoil) begin
      pos = text_plan.size() == 0 ? 0 : $urandom_range(text_plan.size() - 1);
      case ($urandom_range(2))
        0: if (text_plan.size() != 0) text_plan[pos] = pick_text_byte();
        1: if (text_plan.size() != 0) text_plan.delete(pos);
        default: text_plan.insert(pos, pick_text_byte());
      endcase
    end
  endfunction

  task automatic run_glob_case(input int max_len);
    pat_plan.delete();
    send_item(KIND_CLEAR, 8'($urandom_range(255)));
    repeat ($urandom_range(max_len)) begin
      pat_plan.push_back(pick_pattern_byte());
      send_item(KIND_APPEND, pat_plan[$]);
    end
    repeat ($urandom_range(1, 4)) begin
      build_text($urandom_range(9) < 3);
      send_text_and_end();
    end
  endtask

  task automatic test_empty_pattern();
    send_item(KIND_END, 8'h00);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_END, 8'hff);
  endtask

  task automatic test_case_folding();
    send_item(KIND_CLEAR, 8'hff);
    send_item(KIND_APPEND, 8'h41);
    send_item(KIND_APPEND, 8'h7a);
    send_item(KIND_APPEND, 8'h40);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_TEXT, 8'h5a);
    send_item(KIND_TEXT, 8'h40);
    send_item(KIND_END, 8'h00);
    // '@' and '`' differ by the case gap but are not letters
    send_item(KIND_TEXT, 8'h41);
    send_item(KIND_TEXT, 8'h7a);
    send_item(KIND_TEXT, 8'h60);
    send_item(KIND_END, 8'h00);
  endtask

  task automatic test_wildcards();
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_APPEND, STAR_CHAR);
    send_item(KIND_APPEND, ANY_CHAR);
    send_item(KIND_APPEND, 8'h00);
    // question mark cannot match past the end of the text
    send_item(KIND_END, 8'h00);
    send_item(KIND_TEXT, 8'hff);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_END, 8'h00);
    // end of text rearms the pattern; this text ends on '[' and so does not match
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'h5b);
    send_item(KIND_END, 8'h00);
  endtask

  task automatic test_store_full();
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_APPEND, 8'h78);
    send_item(KIND_APPEND, ANY_CHAR);
    repeat (PMAX - 2) send_item(KIND_APPEND, STAR_CHAR);
    repeat (3) send_item(KIND_APPEND, 8'($urandom_range(255)));
    send_item(KIND_TEXT, 8'h58);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'h71);
    send_item(KIND_END, 8'h00);
    send_item(KIND_END, 8'h00);
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_END, 8'h00);
  endtask

  task automatic test_random_traffic();
    int idle_plan [4];
    int stall_plan [4];
    int target;
    int pick;
    idle_plan = '{0, 85, 0, 17};
    stall_plan = '{0, 0, 85, 17};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      target = items_sent + 150;
      while (items_sent < target) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          run_glob_case(48);
        end else if (pick < 3) begin
          repeat ($urandom_range(1, 6)) begin
            send_item(kind_t'($urandom_range(3)), 8'($urandom_range(255)));
          end
        end else begin
          run_glob_case(8);
        end
      end
      wait_for_verdicts();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    error_count = 0;
    items_sent = 0;
    verdict_count = 0;
    match_count = 0;
    overflow_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_case_folding();
    test_wildcards();
    test_store_full();
    test_random_traffic();

    wait_for_verdicts();
    repeat (8) @(negedge clk);
    $display("covered %0d request transactions and %0d verdicts (%0d matches, %0d overflowed)",
             items_sent, verdict_count, match_count, overflow_count);
    $display("with clear, append, text and end mixed under four idle and stall profiles");
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
